// ===== design/wfsm_pkg.sv =====
`default_nettype none

package wfsm_pkg;

    localparam int unsigned PULSE_W = 15;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 2;

    // register indexes of the configuration port
    localparam logic [IDX_W-1:0] CFG_CUTOFF_LIMIT = 2'd0;
    localparam logic [IDX_W-1:0] CFG_REPORT_MIN_P = 2'd1;
    localparam logic [IDX_W-1:0] CFG_REPORT_MIN_S = 2'd2;

    localparam logic [CFG_W-1:0] CUTOFF_RESET = 16'd600;
    localparam logic [CFG_W-1:0] MIN_P_RESET  = 16'd10;
    localparam logic [CFG_W-1:0] MIN_S_RESET  = 16'd3;

    localparam logic [TIME_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [CFG_W-1:0] cutoff_limit_seconds;
        logic [CFG_W-1:0] report_min_pulses;
        logic [CFG_W-1:0] report_min_seconds;
    } t_cfg;

    typedef struct packed {
        logic              valve_close_cmd;
        logic              flow_running;
        logic              flow_started;
        logic              flow_stopped;
        logic              report_valid;
        logic [TIME_W-1:0] session_pulses;
        logic [TIME_W-1:0] session_start;
        logic [TIME_W-1:0] session_stop;
    } t_result;

endpackage

`default_nettype wire

// ===== design/wfsm_cfg.sv =====
`default_nettype none

module wfsm_cfg (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_valid,
    input  wire  [wfsm_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire  [wfsm_pkg::CFG_W-1:0]     i_cfg_data,
    output wfsm_pkg::t_cfg                 o_cfg
);
    import wfsm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CUTOFF_LIMIT: n_cfg.cutoff_limit_seconds = i_cfg_data;
                CFG_REPORT_MIN_P: n_cfg.report_min_pulses    = i_cfg_data;
                CFG_REPORT_MIN_S: n_cfg.report_min_seconds   = i_cfg_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cutoff_limit_seconds <= CUTOFF_RESET;
            r_cfg.report_min_pulses    <= MIN_P_RESET;
            r_cfg.report_min_seconds   <= MIN_S_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/wfsm_core.sv =====
`default_nettype none

module wfsm_core (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_advance,
    input  wire  [wfsm_pkg::PULSE_W-1:0]    i_pulse_count,
    input  wire  [wfsm_pkg::TIME_W-1:0]     i_now_seconds,
    input  wire  wfsm_pkg::t_cfg            i_cfg,
    output wfsm_pkg::t_result               o_result
);
    import wfsm_pkg::*;

    logic               r_running;
    logic [PULSE_W-1:0] r_prev;
    logic [TIME_W-1:0]  r_total;
    logic [TIME_W-1:0]  r_start;
    logic               n_running;
    logic [PULSE_W-1:0] n_prev;
    logic [TIME_W-1:0]  n_total;
    logic [TIME_W-1:0]  n_start;

    logic               changed;
    logic [PULSE_W-1:0] delta;
    logic [TIME_W:0]    sum;
    logic [TIME_W:0]    elapsed;
    t_result            res;

    assign changed = (i_pulse_count != r_prev);
    assign delta   = (i_pulse_count > r_prev) ? (i_pulse_count - r_prev)
                                              : (r_prev - i_pulse_count);
    assign sum     = {1'b0, r_total} + {{(TIME_W + 1 - PULSE_W){1'b0}}, delta};
    // sign bit set means the clock ran backwards
    assign elapsed = {1'b0, i_now_seconds} - {1'b0, r_start};

    always_comb begin
        n_running = r_running;
        n_prev    = r_prev;
        n_total   = r_total;
        n_start   = r_start;
        res       = '0;

        res.valve_close_cmd = r_running && !elapsed[TIME_W] &&
            (elapsed[TIME_W-1:0] >
             {{(TIME_W - CFG_W){1'b0}}, i_cfg.cutoff_limit_seconds});

        if (changed) begin
            n_total   = sum[TIME_W] ? TOTAL_MAX : sum[TIME_W-1:0];
            n_prev    = i_pulse_count;
            n_running = 1'b1;
            if (!r_running) begin
                res.flow_started = 1'b1;
                n_start          = i_now_seconds;
            end
        end else if (r_running) begin
            n_running          = 1'b0;
            res.flow_stopped   = 1'b1;
            res.session_pulses = r_total;
            res.session_start  = r_start;
            res.session_stop   = i_now_seconds;
            res.report_valid   =
                (r_total > {{(TIME_W - CFG_W){1'b0}}, i_cfg.report_min_pulses}) &&
                !elapsed[TIME_W] &&
                (elapsed[TIME_W-1:0] >
                 {{(TIME_W - CFG_W){1'b0}}, i_cfg.report_min_seconds});
            n_total = '0;
            n_start = '0;
        end
        res.flow_running = n_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_prev    <= '0;
            r_total   <= '0;
            r_start   <= '0;
        end else if (i_advance) begin
            r_running <= n_running;
            r_prev    <= n_prev;
            r_total   <= n_total;
            r_start   <= n_start;
        end
    end

    assign o_result = res;

endmodule

`default_nettype wire

// ===== design/water_flow_session_monitor_unit.sv =====
// throughput: one transaction per cycle while the receiver keeps i_out_ready high, set by the session state update
// an input register and a result register decouple the two channels
// reset (synchronous, active low) clears session state and pipeline valids
// and loads the configuration registers with their defaults
`default_nettype none

module water_flow_session_monitor_unit (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [wfsm_pkg::IDX_W-1:0]      i_cfg_index,
    input  wire  [wfsm_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire  [wfsm_pkg::PULSE_W-1:0]    i_pulse_count,
    input  wire  [wfsm_pkg::TIME_W-1:0]     i_now_seconds,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic                            o_valve_close_cmd,
    output logic                            o_flow_running,
    output logic                            o_flow_started,
    output logic                            o_flow_stopped,
    output logic                            o_report_valid,
    output logic [wfsm_pkg::TIME_W-1:0]     o_session_pulses,
    output logic [wfsm_pkg::TIME_W-1:0]     o_session_start,
    output logic [wfsm_pkg::TIME_W-1:0]     o_session_stop
);
    import wfsm_pkg::*;

    logic               r_in_valid;
    logic [PULSE_W-1:0] r_in_count;
    logic [TIME_W-1:0]  r_in_now;
    logic               r_out_valid;
    t_result            r_out;

    logic    advance;
    logic    in_take;
    t_cfg    cfg;
    t_result core_res;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign in_take     = i_in_valid && o_in_ready;

    wfsm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wfsm_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_pulse_count (r_in_count),
        .i_now_seconds (r_in_now),
        .i_cfg         (cfg),
        .o_result      (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_count <= i_pulse_count;
            r_in_now   <= i_now_seconds;
        end
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_valve_close_cmd = r_out.valve_close_cmd;
    assign o_flow_running    = r_out.flow_running;
    assign o_flow_started    = r_out.flow_started;
    assign o_flow_stopped    = r_out.flow_stopped;
    assign o_report_valid    = r_out.report_valid;
    assign o_session_pulses  = r_out.session_pulses;
    assign o_session_start   = r_out.session_start;
    assign o_session_stop    = r_out.session_stop;

endmodule

`default_nettype wire

// ===== design/wfsm_checker.sv =====
`default_nettype none

module wfsm_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire        o_flow_running,
    input wire        o_flow_started,
    input wire        o_flow_stopped,
    input wire        o_report_valid,
    input wire [31:0] o_session_pulses,
    input wire [31:0] o_session_start,
    input wire [31:0] o_session_stop
);

    // a stalled result transaction keeps its session pulse count and stop time
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_session_pulses) && $stable(o_session_stop))
        else $error("result changed while stalled");

    a_start_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_flow_started && o_flow_stopped))
        else $error("session started and stopped on one tick");

    a_stop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_flow_stopped || o_flow_started) |->
            (o_flow_running == o_flow_started))
        else $error("running flag disagrees with start or stop");

    a_report_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_report_valid |-> o_flow_stopped)
        else $error("report without a stopped session");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_flow_stopped |->
            o_session_pulses == 32'd0 && o_session_start == 32'd0 &&
            o_session_stop == 32'd0)
        else $error("session fields set without a stop");

endmodule

bind water_flow_session_monitor_unit wfsm_checker u_wfsm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_flow_running   (o_flow_running),
    .o_flow_started   (o_flow_started),
    .o_flow_stopped   (o_flow_stopped),
    .o_report_valid   (o_report_valid),
    .o_session_pulses (o_session_pulses),
    .o_session_start  (o_session_start),
    .o_session_stop   (o_session_stop)
);

`default_nettype wire

// ===== sim/tb_water_flow_session_monitor_unit.sv =====
`timescale 1ns / 100ps

module tb_water_flow_session_monitor_unit;
    import wfsm_pkg::*;

    // index 3 decodes to no register
    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {RX_STREAM, RX_BUSY, RX_SPARSE} t_rx_mode;

    class flow_scoreboard;
        t_result           expected_q[$];
        int unsigned       errors;
        int unsigned       n_checked;
        logic [CFG_W-1:0]  cutoff_s;
        logic [CFG_W-1:0]  min_pulses;
        logic [CFG_W-1:0]  min_secs;
        bit                running;
        logic [PULSE_W-1:0] last_count;
        logic [TIME_W-1:0] total;
        logic [TIME_W-1:0] start_t;

        function new();
            errors     = 0;
            n_checked  = 0;
            cutoff_s   = CUTOFF_RESET;
            min_pulses = MIN_P_RESET;
            min_secs   = MIN_S_RESET;
            running    = 0;
            last_count = '0;
            total      = '0;
            start_t    = '0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_CUTOFF_LIMIT: cutoff_s = val;
                CFG_REPORT_MIN_P: min_pulses = val;
                CFG_REPORT_MIN_S: min_secs = val;
                default: ;
            endcase
        endfunction

        function void note_input(logic [PULSE_W-1:0] cnt, logic [TIME_W-1:0] now);
            t_result            r;
            longint             elapsed;
            logic [PULSE_W-1:0] delta;
            logic [TIME_W:0]    sum;
            r = '0;
            // signed difference, a clock running backwards never trips a threshold
            elapsed = longint'({32'd0, now}) - longint'({32'd0, start_t});
            if (running && elapsed > longint'({48'd0, cutoff_s}))
                r.valve_close_cmd = 1'b1;
            if (cnt != last_count) begin
                delta = (cnt > last_count) ? cnt - last_count : last_count - cnt;
                sum = {1'b0, total} + {{(TIME_W + 1 - PULSE_W){1'b0}}, delta};
                total = sum[TIME_W] ? TOTAL_MAX : sum[TIME_W-1:0];
                last_count = cnt;
                if (!running) begin
                    r.flow_started = 1'b1;
                    start_t = now;
                end
                running = 1;
            end else if (running) begin
                running = 0;
                r.flow_stopped   = 1'b1;
                r.session_pulses = total;
                r.session_start  = start_t;
                r.session_stop   = now;
                if (total > {16'd0, min_pulses} && elapsed > longint'({48'd0, min_secs}))
                    r.report_valid = 1'b1;
                total   = '0;
                start_t = '0;
            end
            r.flow_running = running;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(t_result act);
            t_result exp_r;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t ns: result with none expected, expected none, actual %0h",
                         $time, act);
                return;
            end
            exp_r = expected_q.pop_front();
            n_checked++;
            compare_field("valve_close_cmd", exp_r.valve_close_cmd, act.valve_close_cmd);
            compare_field("flow_running", exp_r.flow_running, act.flow_running);
            compare_field("flow_started", exp_r.flow_started, act.flow_started);
            compare_field("flow_stopped", exp_r.flow_stopped, act.flow_stopped);
            compare_field("report_valid", exp_r.report_valid, act.report_valid);
            compare_field("session_pulses", exp_r.session_pulses, act.session_pulses);
            compare_field("session_start", exp_r.session_start, act.session_start);
            compare_field("session_stop", exp_r.session_stop, act.session_stop);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [PULSE_W-1:0] i_pulse_count;
    logic [TIME_W-1:0]  i_now_seconds;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_valve_close_cmd;
    logic               o_flow_running;
    logic               o_flow_started;
    logic               o_flow_stopped;
    logic               o_report_valid;
    logic [TIME_W-1:0]  o_session_pulses;
    logic [TIME_W-1:0]  o_session_start;
    logic [TIME_W-1:0]  o_session_stop;

    flow_scoreboard     sb = new;
    int unsigned        burst_left = 0;
    logic [PULSE_W-1:0] gen_count = '0;
    logic [TIME_W-1:0]  gen_time = '0;

    water_flow_session_monitor_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_pulse_count    (i_pulse_count),
        .i_now_seconds    (i_now_seconds),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_valve_close_cmd(o_valve_close_cmd),
        .o_flow_running   (o_flow_running),
        .o_flow_started   (o_flow_started),
        .o_flow_stopped   (o_flow_stopped),
        .o_report_valid   (o_report_valid),
        .o_session_pulses (o_session_pulses),
        .o_session_start  (o_session_start),
        .o_session_stop   (o_session_stop)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #15_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // one poll tick; valid stays high across a burst
    task automatic offer(logic [PULSE_W-1:0] cnt, logic [TIME_W-1:0] now);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_pulse_count <= cnt;
        i_now_seconds <= now;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(cnt, now);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic set_config(logic [CFG_W-1:0] cut, logic [CFG_W-1:0] min_p,
                              logic [CFG_W-1:0] min_s);
        write_reg(CFG_CUTOFF_LIMIT, cut);
        write_reg(CFG_REPORT_MIN_P, min_p);
        write_reg(CFG_REPORT_MIN_S, min_s);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly well-formed sessions with random content, some noise and unfinished ones
    task automatic run_traffic(int unsigned n_items);
        int unsigned        sent;
        int unsigned        len;
        int unsigned        span;
        int unsigned        maxd;
        int unsigned        k;
        bit                 stop_it;
        logic [PULSE_W-1:0] d;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 12) begin
                gen_count = PULSE_W'($urandom);
                gen_time  = $urandom;
                offer(gen_count, gen_time);
                sent++;
            end else begin
                len = $urandom_range(1, 10);
                stop_it = $urandom_range(0, 9) != 0;
                case ($urandom_range(0, 3))
                    0: span = 2;
                    1: span = 40;
                    2: span = sb.cutoff_s / 4 + 1;
                    default: span = sb.cutoff_s + 100;
                endcase
                case ($urandom_range(0, 3))
                    0: maxd = 1;
                    1: maxd = 12;
                    2: maxd = 600;
                    default: maxd = 32767;
                endcase
                for (k = 0; k < len + (stop_it ? 1 : 0); k++) begin
                    if (k < len) begin
                        d = PULSE_W'($urandom_range(1, maxd));
                        gen_count = $urandom_range(0, 1) ? gen_count + d : gen_count - d;
                    end
                    if ($urandom_range(0, 19) == 0)
                        gen_time = gen_time - $urandom_range(1, span);
                    else
                        gen_time = gen_time + $urandom_range(0, span);
                    offer(gen_count, gen_time);
                    sent++;
                end
                // idle ticks with an unchanged reading
                repeat ($urandom_range(0, 2)) begin
                    gen_time = gen_time + 1;
                    offer(gen_count, gen_time);
                end
            end
        end
    endtask

    // receiver: random stall pattern per window, plus one long hold-off
    initial begin
        int unsigned  window_left;
        int unsigned  hold_left;
        bit           held_once;
        logic [31:0]  pat;
        t_rx_mode     mode;
        window_left = 0;
        hold_left   = 0;
        held_once   = 0;
        pat         = '1;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held_once && sb.n_checked >= 300) begin
                held_once = 1;
                hold_left = 200;
            end
            if (window_left == 0) begin
                window_left = 32;
                mode = t_rx_mode'($urandom_range(0, 2));
                case (mode)
                    RX_STREAM: pat = '1;
                    RX_BUSY:   pat = $urandom | $urandom;
                    default:   pat = $urandom & $urandom;
                endcase
            end
            window_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= pat[0];
            end
            pat = {pat[0], pat[31:1]};
        end
    end

    initial begin
        t_result act;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                act.valve_close_cmd = o_valve_close_cmd;
                act.flow_running    = o_flow_running;
                act.flow_started    = o_flow_started;
                act.flow_stopped    = o_flow_stopped;
                act.report_valid    = o_report_valid;
                act.session_pulses  = o_session_pulses;
                act.session_start   = o_session_start;
                act.session_stop    = o_session_stop;
                sb.check_result(act);
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_pulse_count <= '0;
        i_now_seconds <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed ticks under the reset configuration
        offer(15'd0, 32'd100);          // unchanged reading while idle
        offer(15'd5, 32'd100);
        offer(15'h7FFF, 32'd101);
        offer(15'd0, 32'd800);          // past cutoff
        offer(15'd0, 32'd801);          // stop, reported
        offer(15'd0, 32'd802);
        offer(15'd3, 32'd1000);
        offer(15'd3, 32'd1001);         // too few pulses
        offer(15'd20, 32'd2000);
        offer(15'd20, 32'd2003);        // duration equals threshold
        offer(15'd40, 32'd3000);
        offer(15'd40, 32'd3004);
        offer(15'd41, 32'hFFFF_FFF0);
        offer(15'd42, 32'd5);           // clock ran backwards while running
        offer(15'd42, 32'hFFFF_FFFF);
        offer(15'd100, 32'd5000);
        offer(15'd100, 32'd4000);       // negative duration at stop
        offer(15'd200, 32'd10000);
        offer(15'd300, 32'd10600);      // elapsed equals cutoff
        offer(15'd400, 32'd10601);
        offer(15'd0, 32'd10601);
        offer(15'd0, 32'd10602);
        offer(15'h7FFF, 32'd20000);
        offer(15'd0, 32'd20001);
        offer(15'd0, 32'd20002);
        gen_count = 15'd0;
        gen_time  = 32'd20002;
        wait_idle();

        set_config(16'd1, 16'd0, 16'd0);
        run_traffic(150);
        wait_idle();

        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_traffic(150);
        wait_idle();

        write_reg(CFG_UNUSED, CFG_W'($urandom));
        set_config(CFG_W'($urandom_range(1, 2000)), CFG_W'($urandom_range(0, 65535)),
                   CFG_W'($urandom_range(0, 300)));
        run_traffic(150);
        wait_idle();

        set_config(CFG_W'($urandom_range(1, 400)), CFG_W'($urandom_range(0, 2000)),
                   CFG_W'($urandom_range(0, 20)));
        run_traffic(150);
        wait_idle();

        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/wfsm_pkg.sv
design/wfsm_cfg.sv
design/wfsm_core.sv
design/water_flow_session_monitor_unit.sv
design/wfsm_checker.sv
sim/tb_water_flow_session_monitor_unit.sv
